// ===== hdl/urlpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urlpd_pkg - shared types, constants and helpers
// Character codes, configuration register indexes, hex helpers and the
// result group passed from the decoder to the output buffer.
// ----------------------------------------------------------------------------
package urlpd_pkg;

  localparam int LENGTH_BITS_DEF = 16;  // width of the internal byte counter
  localparam int REPORT_BITS     = 16;  // width of the reported length field
  localparam int GROUP_MAX       = 3;   // most bytes released by one input
  localparam int GROUP_CNT_BITS  = 2;

  localparam logic [7:0] CHAR_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_PLUS   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STRICT_MODE = 1'b1;

  // Bytes released by one input, plus the string summary for the final one.
  typedef struct packed {
    logic [GROUP_MAX-1:0][7:0]  bytes;
    logic [GROUP_CNT_BITS-1:0]  count;
    logic                       last;
    logic                       changed;
    logic                       bad_escape;
    logic [REPORT_BITS-1:0]     length;
  } group_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  // Nibble value of a hex digit; 'A'..'F' and 'a'..'f' map to 10..15.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else begin
      v = c - 8'h61 + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/urlpd_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urlpd stream interfaces
// Valid/ready channels for encoded input bytes and decoded result bytes.
// ----------------------------------------------------------------------------
interface urlpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urlpd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        changed;
  logic        bad_escape;
  logic [15:0] decoded_length;

  modport source (output valid, output out_byte, output out_last, output changed,
                  output bad_escape, output decoded_length, input ready);
  modport sink   (input valid, input out_byte, input out_last, input changed,
                  input bad_escape, input decoded_length, output ready);
endinterface
`default_nettype wire

// ===== hdl/urlpd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urlpd_decode - escape state machine and string summary
// Holds config, escape phase, held digit, flags and count; computes the
// group of bytes one input byte releases.
// ----------------------------------------------------------------------------
module urlpd_decode #(
  parameter int LengthBits = urlpd_pkg::LENGTH_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire [urlpd_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire [urlpd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire                                  accept_i,
  input  wire [7:0]                            byte_i,
  input  wire                                  last_i,
  output urlpd_pkg::group_t                    group_o
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  localparam int ExtW = (LengthBits > urlpd_pkg::REPORT_BITS) ?
                        LengthBits : urlpd_pkg::REPORT_BITS;
  localparam logic [LengthBits-1:0] CntMax = {LengthBits{1'b1}};

  phase_e                 phase_q, phase_d;
  logic [7:0]             held_q, held_d;
  logic                   chg_q, chg_d;
  logic                   err_q, err_d;
  logic [LengthBits-1:0]  cnt_q, cnt_d;
  logic                   keep_plus_q, strict_q;

  // idle-path decode of the current byte
  logic       idle_emit, idle_bad, idle_chg, idle_to_pct;
  logic [7:0] idle_byte;
  logic       byte_hex;
  logic       bad, chg;

  logic [LengthBits+1:0]  cnt_sum;
  logic [ExtW-1:0]        cnt_ext;

  assign byte_hex = urlpd_pkg::is_hex(byte_i);

  always_comb begin
    idle_emit   = 1'b1;
    idle_bad    = 1'b0;
    idle_chg    = 1'b0;
    idle_to_pct = 1'b0;
    idle_byte   = byte_i;
    if (byte_i == urlpd_pkg::CHAR_PCT) begin
      if (last_i) begin
        idle_bad = 1'b1;
      end else begin
        idle_emit   = 1'b0;
        idle_to_pct = 1'b1;
      end
    end else if (byte_i == urlpd_pkg::CHAR_PLUS && !keep_plus_q) begin
      idle_chg  = 1'b1;
      idle_byte = urlpd_pkg::CHAR_SPACE;
    end
  end

  always_comb begin
    group_o.bytes = '0;
    group_o.count = '0;
    bad     = 1'b0;
    chg     = 1'b0;
    phase_d = PH_IDLE;
    held_d  = held_q;
    case (phase_q)
      PH_PCT: begin
        if (byte_hex) begin
          if (last_i) begin
            bad = 1'b1;
            group_o.bytes[0] = urlpd_pkg::CHAR_PCT;
            group_o.bytes[1] = byte_i;
            group_o.count    = 2'd2;
          end else begin
            held_d  = byte_i;
            phase_d = PH_DIGIT;
          end
        end else begin
          bad = 1'b1;
          chg = idle_chg;
          group_o.bytes[0] = urlpd_pkg::CHAR_PCT;
          group_o.bytes[1] = idle_byte;
          group_o.count    = 2'd1 + {1'b0, idle_emit};
          if (idle_to_pct) phase_d = PH_PCT;
          bad = bad | idle_bad;
        end
      end
      PH_DIGIT: begin
        if (byte_hex) begin
          chg = 1'b1;
          group_o.bytes[0] = {urlpd_pkg::hex_value(held_q), urlpd_pkg::hex_value(byte_i)};
          group_o.count    = 2'd1;
        end else begin
          bad = 1'b1;
          chg = idle_chg;
          group_o.bytes[0] = urlpd_pkg::CHAR_PCT;
          group_o.bytes[1] = held_q;
          group_o.bytes[2] = idle_byte;
          group_o.count    = 2'd2 + {1'b0, idle_emit};
          if (idle_to_pct) phase_d = PH_PCT;
        end
      end
      default: begin
        // unused phase code acts as idle
        bad = idle_bad;
        chg = idle_chg;
        group_o.bytes[0] = idle_byte;
        group_o.count    = {1'b0, idle_emit};
        if (idle_to_pct) phase_d = PH_PCT;
      end
    endcase

    chg_d   = chg_q | chg;
    err_d   = err_q | (bad & strict_q);
    cnt_sum = {2'b00, cnt_q} + (LengthBits + 2)'(group_o.count);
    cnt_d   = (cnt_sum > {2'b00, CntMax}) ? CntMax : cnt_sum[LengthBits-1:0];
    cnt_ext = ExtW'(cnt_d);

    group_o.last       = last_i;
    group_o.changed    = chg_d;
    group_o.bad_escape = err_d;
    group_o.length     = (cnt_ext > ExtW'({urlpd_pkg::REPORT_BITS{1'b1}})) ?
                         {urlpd_pkg::REPORT_BITS{1'b1}} :
                         cnt_ext[urlpd_pkg::REPORT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_plus_q <= 1'b0;
      strict_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        urlpd_pkg::CFG_KEEP_PLUS:   keep_plus_q <= cfg_data_i[0];
        urlpd_pkg::CFG_STRICT_MODE: strict_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
      chg_q   <= 1'b0;
      err_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        phase_q <= PH_IDLE;
        held_q  <= '0;
        chg_q   <= 1'b0;
        err_q   <= 1'b0;
        cnt_q   <= '0;
      end else begin
        phase_q <= phase_d;
        held_q  <= held_d;
        chg_q   <= chg_d;
        err_q   <= err_d;
        cnt_q   <= cnt_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/urlpd_outbuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// urlpd_outbuf - result group register and byte serializer
// Holds up to three released bytes and hands them out one per transfer.
// ----------------------------------------------------------------------------
module urlpd_outbuf (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  urlpd_pkg::group_t  group_i,
  input  wire                load_i,
  output logic               space_o,
  urlpd_out_if.source        out_o
);

  logic [urlpd_pkg::GROUP_MAX-1:0][7:0]  buf_q;
  logic [urlpd_pkg::GROUP_CNT_BITS-1:0]  rem_q;
  logic                                  last_q, chg_q, bad_q;
  logic [urlpd_pkg::REPORT_BITS-1:0]     len_q;
  logic                                  final_beat, xfer;

  assign final_beat = last_q && (rem_q == 2'd1);
  assign xfer       = out_o.valid && out_o.ready;
  // room for a new group once the last held byte leaves this cycle
  assign space_o    = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_o.ready);

  assign out_o.valid          = (rem_q != 2'd0);
  assign out_o.out_byte       = buf_q[0];
  assign out_o.out_last       = final_beat;
  assign out_o.changed        = final_beat & chg_q;
  assign out_o.bad_escape     = final_beat & bad_q;
  assign out_o.decoded_length = final_beat ? len_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= group_i.count;
    end else if (xfer) begin
      rem_q <= rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q  <= group_i.bytes;
      last_q <= group_i.last;
      chg_q  <= group_i.changed;
      bad_q  <= group_i.bad_escape;
      len_q  <= group_i.length;
    end else if (xfer) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/url_percent_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder_unit - streaming URL percent decoder
// Decodes %XX escapes and '+' (unless keep_plus) byte by byte, passes bad escapes
// through literally and reports changed / error (strict only) / length on the last byte out.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                         | transfer
//  --------+-----+-------------------------------------------------+-----------------
//  in_i    | in  | in_byte[7:0], in_last                           | valid & ready
//  out_o   | out | out_byte[7:0], out_last, changed, bad_escape,   | valid & ready
//          |     | decoded_length[15:0]                            |
//  cfg     | in  | cfg_we_i, cfg_index_i (0 keep_plus, 1 strict),  | cfg_we_i high
//          |     | cfg_data_i[0]                                   |
//
// Each input byte is decoded in the cycle it transfers and its group of zero
// to three result bytes lands in the output buffer. The buffer hands out one
// byte per cycle while out_o.ready is high; an input that releases several
// bytes, such as a failed escape that releases three, holds off the next
// input until its final byte is leaving; the serializer sets that pace.
// in_i.ready is high while the buffer is empty or its final byte is leaving,
// so a new input can transfer in the same cycle the previous result does.
// Output stalls hold the buffer and back-pressure the input.
// Reset (rst_ni, async low) clears escape state, flags, count, config and
// the buffer; no warm-up is needed.
// ----------------------------------------------------------------------------
module url_percent_decoder_unit #(
  parameter int LengthBits = urlpd_pkg::LENGTH_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [urlpd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire [urlpd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  urlpd_in_if.sink                            in_i,
  urlpd_out_if.source                         out_o
);

  urlpd_pkg::group_t group;
  logic              space;
  logic              accept;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  // escape state machine; state advances only on an input transfer
  urlpd_decode #(
    .LengthBits (LengthBits)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (in_i.in_byte),
    .last_i      (in_i.in_last),
    .group_o     (group)
  );

  // result register and serializer
  urlpd_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .group_i (group),
    .load_i  (accept),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
